FILE: hw/rtl/lap_pkg.sv
// ----------------------------------------------------------------------------
// lap_pkg
// Shared types, constants and coefficient tables of the linkage angle
// polynomial block.
// ----------------------------------------------------------------------------
package lap_pkg;

  localparam int unsigned POLY_DEGREE = 7;
  localparam int unsigned ANGLE_BITS  = 16;
  localparam int unsigned FRAC_BITS   = 13;
  localparam int unsigned COEF_FRAC   = 28;
  localparam int unsigned OUT_SHIFT   = COEF_FRAC - FRAC_BITS;

  // Both Horner accumulators stay below 2^41 in magnitude for any input.
  localparam int unsigned ACC_W  = 44;
  localparam int unsigned PROD_W = ACC_W + ANGLE_BITS;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_LOWER_LIMIT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UPPER_LIMIT = 8'd1;

  localparam logic signed [ANGLE_BITS-1:0] LOWER_RESET = 16'sd0;
  localparam logic signed [ANGLE_BITS-1:0] UPPER_RESET = 16'sd16384;

  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [ANGLE_BITS-1:0] angle_t;

  // Radian coefficients in Q.28, constant term first.
  localparam acc_t POLY_COEF [0:POLY_DEGREE] = '{
    44'sd48766, 44'sd247598397, 44'sd76741421, -44'sd64270037,
    -44'sd55451084, 44'sd117559818, -44'sd71640845, 44'sd16190891
  };

  // Derivative coefficients i * a_i; the constant entry is never used.
  localparam acc_t DERIV_COEF [0:POLY_DEGREE] = '{
    44'sd0, 44'sd247598397, 44'sd153482842, -44'sd192810111,
    -44'sd221804336, 44'sd587799090, -44'sd429845070, 44'sd113336237
  };

  // Word handed from one cell of the chain to the next.
  typedef struct packed {
    angle_t x;
    logic   fault;
    acc_t   acc;
    acc_t   dacc;
  } lap_word_t;

endpackage

FILE: hw/rtl/lap_if.sv
// ----------------------------------------------------------------------------
// lap_if
// Valid/ready channels of the linkage angle polynomial block: input angle,
// result and configuration write.
// ----------------------------------------------------------------------------
interface lap_in_if;
  logic           valid;
  logic           ready;
  lap_pkg::angle_t proximal_angle;

  modport source (output valid, output proximal_angle, input ready);
  modport sink   (input valid, input proximal_angle, output ready);
endinterface

interface lap_out_if;
  logic            valid;
  logic            ready;
  lap_pkg::angle_t distal_angle;
  lap_pkg::angle_t speed_ratio_out;
  logic            limit_fault;

  modport source (output valid, output distal_angle, output speed_ratio_out,
                  output limit_fault, input ready);
  modport sink   (input valid, input distal_angle, input speed_ratio_out,
                  input limit_fault, output ready);
endinterface

interface lap_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lap_pkg::CFG_INDEX_W-1:0]    index;
  logic [lap_pkg::ANGLE_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/lap_limit_stage.sv
// ----------------------------------------------------------------------------
// lap_limit_stage
// Holds the angle limit registers, checks each incoming angle against them
// and seeds the Horner accumulators with the leading coefficients.
// ----------------------------------------------------------------------------
module lap_limit_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  lap_cfg_if.sink            cfg_i,
  lap_in_if.sink             in_i,
  output logic               valid_o,
  input  logic               ready_i,
  output lap_pkg::lap_word_t word_o
);

  lap_pkg::angle_t    lower_q, upper_q;
  logic               valid_q;
  lap_pkg::lap_word_t word_q, word_d;
  logic               take;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= lap_pkg::LOWER_RESET;
      upper_q <= lap_pkg::UPPER_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        lap_pkg::REG_LOWER_LIMIT: lower_q <= signed'(cfg_i.data);
        lap_pkg::REG_UPPER_LIMIT: upper_q <= signed'(cfg_i.data);
        default: ;
      endcase
    end
  end

  assign in_i.ready = !valid_q || ready_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    word_d.x     = in_i.proximal_angle;
    word_d.fault = (in_i.proximal_angle < lower_q) || (in_i.proximal_angle > upper_q);
    word_d.acc   = lap_pkg::POLY_COEF[lap_pkg::POLY_DEGREE];
    word_d.dacc  = lap_pkg::DERIV_COEF[lap_pkg::POLY_DEGREE];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

FILE: hw/rtl/lap_horner_cell.sv
// ----------------------------------------------------------------------------
// lap_horner_cell
// One Horner step of the polynomial and, in every cell but the last, of its
// derivative, with its own valid/ready stage register.
// ----------------------------------------------------------------------------
module lap_horner_cell #(
  parameter int unsigned COEF_IDX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  lap_pkg::lap_word_t word_i,
  output logic               valid_o,
  input  logic               ready_i,
  output lap_pkg::lap_word_t word_o
);

  localparam logic signed [lap_pkg::PROD_W-1:0] ROUND_HALF =
    lap_pkg::PROD_W'(1) << (lap_pkg::FRAC_BITS - 1);

  logic                                valid_q;
  lap_pkg::lap_word_t                  word_q, word_d;
  logic signed [lap_pkg::PROD_W-1:0]   prod, prod_sh;

  // Product rounded half toward plus infinity, then shifted back to Q.28.
  assign prod    = word_i.acc * word_i.x;
  assign prod_sh = (prod + ROUND_HALF) >>> lap_pkg::FRAC_BITS;

  generate
    if (COEF_IDX >= 1) begin : g_deriv
      logic signed [lap_pkg::PROD_W-1:0] dprod, dprod_sh;
      assign dprod    = word_i.dacc * word_i.x;
      assign dprod_sh = (dprod + ROUND_HALF) >>> lap_pkg::FRAC_BITS;
      assign word_d.dacc = signed'(dprod_sh[lap_pkg::ACC_W-1:0])
                         + lap_pkg::DERIV_COEF[COEF_IDX];
    end else begin : g_pass
      // The derivative has one step fewer; the last cell carries it through.
      assign word_d.dacc = word_i.dacc;
    end
  endgenerate

  assign word_d.x     = word_i.x;
  assign word_d.fault = word_i.fault;
  assign word_d.acc   = signed'(prod_sh[lap_pkg::ACC_W-1:0]) + lap_pkg::POLY_COEF[COEF_IDX];

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

FILE: hw/rtl/lap_out_stage.sv
// ----------------------------------------------------------------------------
// lap_out_stage
// Rounds both accumulators from Q.28 to Q2.13 and saturates them, or zeroes
// them for a faulted word, and holds the result word for the output channel.
// ----------------------------------------------------------------------------
module lap_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  lap_pkg::lap_word_t word_i,
  lap_out_if.source          out_o
);

  localparam lap_pkg::acc_t ROUND_HALF = lap_pkg::ACC_W'(1) << (lap_pkg::OUT_SHIFT - 1);
  localparam lap_pkg::acc_t SAT_HI =
    lap_pkg::ACC_W'((64'sd1 <<< (lap_pkg::ANGLE_BITS - 1)) - 64'sd1);
  localparam lap_pkg::acc_t SAT_LO = -SAT_HI - lap_pkg::ACC_W'(1);

  function automatic lap_pkg::angle_t to_field(lap_pkg::acc_t v);
    lap_pkg::acc_t r;
    r = (v + ROUND_HALF) >>> lap_pkg::OUT_SHIFT;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return signed'(r[lap_pkg::ANGLE_BITS-1:0]);
  endfunction

  logic            valid_q;
  lap_pkg::angle_t distal_q, speed_q;
  logic            fault_q;

  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      fault_q  <= word_i.fault;
      distal_q <= word_i.fault ? '0 : to_field(word_i.acc);
      speed_q  <= word_i.fault ? '0 : to_field(word_i.dacc);
    end
  end

  assign out_o.valid           = valid_q;
  assign out_o.distal_angle    = distal_q;
  assign out_o.speed_ratio_out = speed_q;
  assign out_o.limit_fault     = fault_q;

endmodule

FILE: hw/rtl/linkage_angle_polynomial.sv
// ----------------------------------------------------------------------------
// linkage_angle_polynomial
// Maps a proximal joint angle to the distal angle and the speed ratio of the
// linkage by a degree-7 polynomial and its derivative, with a limit check.
// ----------------------------------------------------------------------------
// Path: an accepted angle word passes the limit stage, the Horner cells and
//   the output stage, each holding one word, before its result word leaves.
// Throughput: one word per cycle when the output does not stall, set by the
//   chain of one limit stage, seven Horner cells and one output stage.
// Reset: clears every valid flag at once and sets the limits to 0 rad and
//   2.0 rad; payload registers are not reset.
// ----------------------------------------------------------------------------
module linkage_angle_polynomial (
  input  logic       clk_i,
  input  logic       rst_ni,
  lap_cfg_if.sink    cfg_i,
  lap_in_if.sink     in_i,
  lap_out_if.source  out_o
);

  localparam int unsigned NSTAGE = lap_pkg::POLY_DEGREE + 1;

  // Stage 0 is the limit stage; stage k is the k-th Horner cell. Every stage
  // has its own valid flag and a ready that looks only at its own flag and
  // at the stage downstream, so a stalled output still lets empty stages
  // upstream fill.
  logic               stage_valid [0:NSTAGE-1];
  logic               stage_ready [0:NSTAGE-1];
  lap_pkg::lap_word_t stage_word  [0:NSTAGE-1];

  lap_limit_stage u_limit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .in_i    (in_i),
    .valid_o (stage_valid[0]),
    .ready_i (stage_ready[0]),
    .word_o  (stage_word[0])
  );

  // Cell k applies the coefficient of power POLY_DEGREE - k, so the chain
  // walks Horner's rule from the leading term down to the constant term.
  for (genvar k = 1; k < NSTAGE; k++) begin : g_cell
    lap_horner_cell #(
      .COEF_IDX (lap_pkg::POLY_DEGREE - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[k-1]),
      .ready_o (stage_ready[k-1]),
      .word_i  (stage_word[k-1]),
      .valid_o (stage_valid[k]),
      .ready_i (stage_ready[k]),
      .word_o  (stage_word[k])
    );
  end

  // The output register parts the chain from the consumer; a faulted word
  // leaves here with both results forced to zero.
  lap_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid[NSTAGE-1]),
    .ready_o (stage_ready[NSTAGE-1]),
    .word_i  (stage_word[NSTAGE-1]),
    .out_o   (out_o)
  );

endmodule

FILE: hw/rtl/lap_checker.sv
// ----------------------------------------------------------------------------
// lap_props
// Port-level checks of the linkage angle polynomial block: in-flight word
// count bounds, fault results, input readiness and output stall behaviour.
// ----------------------------------------------------------------------------
module lap_props (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input lap_pkg::angle_t distal_angle_i,
  input lap_pkg::angle_t speed_ratio_out_i,
  input logic            limit_fault_i
);

  // Words held inside: limit stage, seven cells and the output register.
  localparam logic [3:0] DEPTH = 4'd9;

  logic [3:0] inflight_q, inflight_d;
  logic       in_take, out_take;

  assign in_take  = in_valid_i && in_ready_i;
  assign out_take = out_valid_i && out_ready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_take && !out_take) begin
      inflight_d = inflight_q + 4'd1;
    end else if (out_take && !in_take) begin
      inflight_d = inflight_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(distal_angle_i)
      && $stable(speed_ratio_out_i) && $stable(limit_fault_i))
    else $error("result word changed while stalled");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && limit_fault_i |-> distal_angle_i == '0 && speed_ratio_out_i == '0)
    else $error("faulted word carries non-zero results");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with an empty output register");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != 4'd0)
    else $error("result word without a matching input word");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= DEPTH)
    else $error("more words inside than the chain can hold");

endmodule

bind linkage_angle_polynomial lap_props u_lap_props (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .distal_angle_i    (out_o.distal_angle),
  .speed_ratio_out_i (out_o.speed_ratio_out),
  .limit_fault_i     (out_o.limit_fault)
);
